// ===== src/aisfd_pkg.sv =====
// ----------------------------------------------------------------------------
// aisfd_pkg
// Shared types and constants of the analog input scaler, filter and deadband.
// ----------------------------------------------------------------------------
`default_nettype none

package aisfd_pkg;

	// fixed field widths
	localparam int RAW_W     = 16;
	localparam int TMS_W     = 16;
	localparam int TUS_W     = 26;
	localparam int DB_W      = 31;
	localparam int MODE_W    = 2;
	localparam int REG_IDX_W = 3;
	localparam int Q_FRAC    = 16;

	// time and value constants
	localparam logic [9:0] MS_US     = 10'd1000;
	localparam int         REPORT_US = 60_000_000;
	localparam int         Q_ONE     = 65536;

	typedef enum logic [1:0] {
		QUAL_GOOD     = 2'd0,
		QUAL_NOT_CONN = 2'd1,
		QUAL_WAITING  = 2'd2
	} qual_t;

	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_ANALOG = 2'd0;
	localparam mode_t MODE_ABOVE  = 2'd1;
	localparam mode_t MODE_BELOW  = 2'd2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RAW_LOW,
		REG_RAW_HIGH,
		REG_ENG_LOW,
		REG_ENG_HIGH,
		REG_FILTER_MS,
		REG_MODE,
		REG_THRESHOLD,
		REG_DEADBAND
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MAG,
		ST_SDIV_GO,
		ST_SDIV_WAIT,
		ST_SCALE,
		ST_CLAMP,
		ST_FPREP,
		ST_FMAG,
		ST_FDIV_GO,
		ST_FDIV_WAIT,
		ST_FILT,
		ST_DISC,
		ST_DECIDE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mag;
		logic sdiv_go;
		logic scale;
		logic clamp;
		logic fprep;
		logic fmag;
		logic fdiv_go;
		logic filt;
		logic disc;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic bypass;
		logic filt_en;
		logic div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== src/aisfd_div.sv =====
// ----------------------------------------------------------------------------
// aisfd_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aisfd_div import aisfd_pkg::*; #(
	parameter int DIVIDEND_W = 58,
	parameter int DIVISOR_W  = 49
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic      [DIVIDEND_W-1:0] quotient,
	output logic                       done
);

	localparam int STEPS = DIVIDEND_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W-1:0]  rem_n;
	logic [DIVIDEND_W-1:0] quo_n;

	// two restoring steps; dividend bits shift out the top, quotient bits in
	always_comb begin
		logic [DIVISOR_W:0] trial;
		logic [DIVISOR_W:0] diff;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, quo_n[DIVIDEND_W-1]};
			diff  = trial - {1'b0, den_q};
			if (trial >= {1'b0, den_q}) begin
				rem_n = diff[DIVISOR_W-1:0];
				quo_n = {quo_n[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_n = trial[DIVISOR_W-1:0];
				quo_n = {quo_n[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== src/aisfd_dp.sv =====
// ----------------------------------------------------------------------------
// aisfd_dp
// Datapath: config registers, scaling, clamp, lag filter, discrete mode,
// deadband decision, report state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aisfd_dp import aisfd_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int TIME_WIDTH  = 48,
	parameter int CFG_W       = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [REG_IDX_W-1:0]   cfg_addr,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic [RAW_W-1:0]       raw_sample,
	input  wire logic                   link_error,
	input  wire logic [TIME_WIDTH-1:0]  now_us,
	input  wire logic                   sim_enable,
	input  wire logic [VALUE_WIDTH-1:0] sim_value,
	input  wire dp_cmd_t                cmd,
	output dp_stat_t                    stat,
	output logic      [VALUE_WIDTH-1:0] value,
	output qual_t                       quality,
	output logic                        reported
);

	localparam int W      = VALUE_WIDTH;
	localparam int TW     = TIME_WIDTH;
	localparam int SC_W   = W + RAW_W;
	localparam int FP_W   = W + TUS_W;
	localparam int DIV_N  = ((FP_W + 1) / 2) * 2;
	localparam int DIV_D  = TW + 1;
	localparam int SCL_W  = SC_W + 2;
	localparam int CMP_W  = ((W > DB_W) ? W : DB_W) + 2;
	localparam logic [W-1:0] ONE_W = W'(Q_ONE);

	// configuration
	logic [RAW_W-1:0] raw_lo_q, raw_hi_q;
	logic [W-1:0]     eng_lo_q, eng_hi_q, thr_q;
	logic [TMS_W-1:0] ftm_q;
	mode_t            mode_q;
	logic [DB_W-1:0]  db_q;

	// item
	logic [RAW_W-1:0] raw_q;
	logic             lerr_q;
	logic [TW-1:0]    now_q;
	logic             sim_en_q;
	logic [W-1:0]     sim_val_q;

	// working registers
	logic [W:0]       e_rng_q;
	logic [RAW_W:0]   r_rng_q, off_q;
	logic [TW-1:0]    dt_q;
	logic [W-1:0]     v_q;
	logic [W-1:0]     am_q;
	logic [RAW_W-1:0] bm_q, cm_q;
	logic             sneg_q;
	logic [SCL_W-1:0] sc_q;
	logic [TUS_W-1:0] tq_q;
	logic [W:0]       d_q;
	logic [DIV_D-1:0] den_q;
	logic [W-1:0]     dm_q;
	logic             fneg_q;

	// report state
	logic [W-1:0]     last_val_q;
	logic [TW-1:0]    last_time_q;
	qual_t            cur_qual_q;

	// output register
	logic [W-1:0]     out_val_q;
	qual_t            out_qual_q;
	logic             out_rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_lo_q <= '0;
			raw_hi_q <= '0;
			eng_lo_q <= '0;
			eng_hi_q <= '0;
			ftm_q    <= '0;
			mode_q   <= MODE_ANALOG;
			thr_q    <= '0;
			db_q     <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_RAW_LOW:   raw_lo_q <= cfg_data[RAW_W-1:0];
				REG_RAW_HIGH:  raw_hi_q <= cfg_data[RAW_W-1:0];
				REG_ENG_LOW:   eng_lo_q <= cfg_data[W-1:0];
				REG_ENG_HIGH:  eng_hi_q <= cfg_data[W-1:0];
				REG_FILTER_MS: ftm_q    <= cfg_data[TMS_W-1:0];
				REG_MODE:      mode_q   <= cfg_data[MODE_W-1:0];
				REG_THRESHOLD: thr_q    <= cfg_data[W-1:0];
				REG_DEADBAND:  db_q     <= cfg_data[DB_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------ prep
	logic [TW:0]   dt_fwd;
	logic [TW-1:0] dt_bwd;
	logic [W-1:0]  v_byp;
	qual_t         new_qual;

	assign dt_fwd   = {1'b0, now_q} - {1'b0, last_time_q};
	assign dt_bwd   = last_time_q - now_q;
	assign v_byp    = sim_en_q ? sim_val_q : W'($signed({raw_q, {Q_FRAC{1'b0}}}));
	assign new_qual = sim_en_q ? QUAL_GOOD : (lerr_q ? QUAL_NOT_CONN : QUAL_GOOD);

	// ------------------------------------------------------------------- mag
	logic [W:0]     e_abs;
	logic [RAW_W:0] off_abs, r_abs;

	assign e_abs   = e_rng_q[W] ? (~e_rng_q + 1'b1) : e_rng_q;
	assign off_abs = off_q[RAW_W] ? (~off_q + 1'b1) : off_q;
	assign r_abs   = r_rng_q[RAW_W] ? (~r_rng_q + 1'b1) : r_rng_q;

	// -------------------------------------------------------------- divider
	logic [SC_W-1:0]  sprod;
	logic [FP_W-1:0]  fprod;
	logic             div_start;
	logic [DIV_N-1:0] div_a;
	logic [DIV_D-1:0] div_b;
	logic [DIV_N-1:0] div_quo;
	logic             div_done;

	assign sprod     = am_q * bm_q;
	assign fprod     = dm_q * tq_q;
	assign div_start = cmd.sdiv_go | cmd.fdiv_go;
	assign div_a     = cmd.sdiv_go ? DIV_N'(sprod) : DIV_N'(fprod);
	assign div_b     = cmd.sdiv_go ? DIV_D'(cm_q) : den_q;

	aisfd_div #(
		.DIVIDEND_W (DIV_N),
		.DIVISOR_W  (DIV_D)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_quo),
		.done     (div_done)
	);

	// ---------------------------------------------------------- scale, clamp
	logic [SCL_W-1:0] sq_mag, sq, elo_x, ehi_x, clamp_hi, clamp_v;
	logic [TUS_W-1:0] tq_n;

	assign sq_mag   = {2'b00, div_quo[SC_W-1:0]};
	assign sq       = sneg_q ? (~sq_mag + 1'b1) : sq_mag;
	assign elo_x    = SCL_W'($signed(eng_lo_q));
	assign ehi_x    = SCL_W'($signed(eng_hi_q));
	assign clamp_hi = ($signed(sc_q) > $signed(ehi_x)) ? ehi_x : sc_q;
	assign clamp_v  = ($signed(clamp_hi) < $signed(elo_x)) ? elo_x : clamp_hi;
	assign tq_n     = TUS_W'(ftm_q) * TUS_W'(MS_US);

	// ---------------------------------------------------------------- filter
	logic [W:0] d_abs, fq_mag, fq, v_filt;

	assign d_abs  = d_q[W] ? (~d_q + 1'b1) : d_q;
	assign fq_mag = {1'b0, div_quo[W-1:0]};
	assign fq     = fneg_q ? (~fq_mag + 1'b1) : fq_mag;
	assign v_filt = {v_q[W-1], v_q} - fq;

	// -------------------------------------------------------------- decision
	logic signed [CMP_W-1:0] diff, db_x, db_neg;
	logic                    rep;

	assign diff   = CMP_W'($signed(v_q)) - CMP_W'($signed(last_val_q));
	assign db_x   = CMP_W'(db_q);
	assign db_neg = -db_x;
	assign rep    = (diff >= db_x) || (diff <= db_neg) || (new_qual != cur_qual_q)
		|| (dt_q > TW'(REPORT_US));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q     <= raw_sample;
			lerr_q    <= link_error;
			now_q     <= now_us;
			sim_en_q  <= sim_enable;
			sim_val_q <= sim_value;
		end
		if (cmd.prep) begin
			e_rng_q <= {eng_hi_q[W-1], eng_hi_q} - {eng_lo_q[W-1], eng_lo_q};
			r_rng_q <= {raw_hi_q[RAW_W-1], raw_hi_q} - {raw_lo_q[RAW_W-1], raw_lo_q};
			off_q   <= {raw_q[RAW_W-1], raw_q} - {raw_lo_q[RAW_W-1], raw_lo_q};
			dt_q    <= dt_fwd[TW] ? dt_bwd : dt_fwd[TW-1:0];
			v_q     <= v_byp;
		end
		if (cmd.mag) begin
			am_q   <= e_abs[W-1:0];
			bm_q   <= off_abs[RAW_W-1:0];
			cm_q   <= r_abs[RAW_W-1:0];
			sneg_q <= e_rng_q[W] ^ off_q[RAW_W] ^ r_rng_q[RAW_W];
		end
		if (cmd.scale) begin
			sc_q <= elo_x + sq;
		end
		if (cmd.clamp) begin
			v_q  <= clamp_v[W-1:0];
			tq_q <= tq_n;
		end
		if (cmd.fprep) begin
			d_q   <= {v_q[W-1], v_q} - {last_val_q[W-1], last_val_q};
			den_q <= DIV_D'(tq_q) + DIV_D'(dt_q);
		end
		if (cmd.fmag) begin
			dm_q   <= d_abs[W-1:0];
			fneg_q <= d_q[W];
		end
		if (cmd.filt) begin
			v_q <= v_filt[W-1:0];
		end
		if (cmd.disc) begin
			case (mode_q)
				MODE_ABOVE: v_q <= ($signed(v_q) >= $signed(thr_q)) ? ONE_W : '0;
				MODE_BELOW: v_q <= ($signed(v_q) < $signed(thr_q)) ? ONE_W : '0;
				default:    v_q <= v_q;
			endcase
		end
		if (cmd.commit) begin
			out_val_q  <= v_q;
			out_qual_q <= new_qual;
			out_rep_q  <= rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_val_q  <= '0;
			last_time_q <= '0;
			cur_qual_q  <= QUAL_WAITING;
		end else if (cmd.commit) begin
			cur_qual_q <= new_qual;
			if (rep) begin
				last_val_q  <= v_q;
				last_time_q <= now_q;
			end
		end
	end

	assign stat.bypass   = sim_en_q || (raw_hi_q == raw_lo_q) || (eng_hi_q == eng_lo_q);
	assign stat.filt_en  = (dt_q != '0) && (ftm_q != '0);
	assign stat.div_done = div_done;

	assign value    = out_val_q;
	assign quality  = out_qual_q;
	assign reported = out_rep_q;

endmodule

`default_nettype wire

// ===== src/aisfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// aisfd_ctrl
// Controller: sequences one item through the datapath and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module aisfd_ctrl import aisfd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_n = ST_PREP;
			ST_PREP:      state_n = stat.bypass ? ST_DECIDE : ST_MAG;
			ST_MAG:       state_n = ST_SDIV_GO;
			ST_SDIV_GO:   state_n = ST_SDIV_WAIT;
			ST_SDIV_WAIT: if (stat.div_done) state_n = ST_SCALE;
			ST_SCALE:     state_n = ST_CLAMP;
			ST_CLAMP:     state_n = stat.filt_en ? ST_FPREP : ST_DISC;
			ST_FPREP:     state_n = ST_FMAG;
			ST_FMAG:      state_n = ST_FDIV_GO;
			ST_FDIV_GO:   state_n = ST_FDIV_WAIT;
			ST_FDIV_WAIT: if (stat.div_done) state_n = ST_FILT;
			ST_FILT:      state_n = ST_DISC;
			ST_DISC:      state_n = ST_DECIDE;
			ST_DECIDE:    if (out_free) state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_PREP:      cmd.prep    = 1'b1;
			ST_MAG:       cmd.mag     = 1'b1;
			ST_SDIV_GO:   cmd.sdiv_go = 1'b1;
			ST_SDIV_WAIT: cmd.scale   = stat.div_done;
			ST_SCALE:     cmd.clamp   = 1'b1;
			ST_CLAMP:     cmd.fprep   = stat.filt_en;
			ST_FPREP:     cmd.fmag    = 1'b1;
			ST_FMAG:      cmd.fmag    = 1'b0;
			ST_FDIV_GO:   cmd.fdiv_go = 1'b1;
			ST_FDIV_WAIT: cmd.filt    = stat.div_done;
			ST_FILT:      cmd.disc    = 1'b0;
			// reached from both the filtered and the unfiltered path
			ST_DISC:      cmd.disc    = 1'b1;
			ST_DECIDE:    cmd.commit  = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/analog_input_scaler_filter_deadband.sv =====
// ----------------------------------------------------------------------------
// analog_input_scaler_filter_deadband
// Analog input conditioning: linear scaling with clamp, lag filter against
// the last reported value, discrete threshold and deadband reporting.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_we               cfg_addr (register index), cfg_data
//  in       s_tvalid / s_tready  s_tdata, s_tuser
//  out      m_tvalid / m_tready  m_tdata, m_tuser
//
// one item at a time; a simulated item or degenerate ranges skip scaling,
// lag filter and discrete mode, and the lag filter is also skipped when
// the filter time or the time since the last report is zero.
// the divider retires two quotient bits a cycle and runs once for scaling
// and once for the filter. the result waits in the output register while
// the next item is taken; only the next commit waits on m_tready.
// reset clears the config registers, last value and time, quality to waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_input_scaler_filter_deadband import aisfd_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int TIME_WIDTH  = 48,
	localparam int CFG_W      = (VALUE_WIDTH > DB_W) ? VALUE_WIDTH : DB_W,
	localparam int S_DATA_W   = ((RAW_W + TIME_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
	localparam int M_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_DATA_W-1:0]  s_tdata,  // raw_sample, now_us, sim_value
	input  wire logic [1:0]           s_tuser,  // link_error, sim_enable
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_DATA_W-1:0]  m_tdata,  // value
	output logic      [2:0]           m_tuser   // quality[1:0], reported
);

	localparam int NOW_LO = RAW_W;
	localparam int SIM_LO = RAW_W + TIME_WIDTH;

	dp_cmd_t                cmd;
	dp_stat_t               stat;
	logic [VALUE_WIDTH-1:0] value;
	qual_t                  quality;
	logic                   reported;

	aisfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	aisfd_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH),
		.CFG_W       (CFG_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.raw_sample (s_tdata[RAW_W-1:0]),
		.link_error (s_tuser[0]),
		.now_us     (s_tdata[NOW_LO +: TIME_WIDTH]),
		.sim_enable (s_tuser[1]),
		.sim_value  (s_tdata[SIM_LO +: VALUE_WIDTH]),
		.cmd        (cmd),
		.stat       (stat),
		.value      (value),
		.quality    (quality),
		.reported   (reported)
	);

	assign m_tdata = M_DATA_W'(value);
	assign m_tuser = {reported, quality};

endmodule

`default_nettype wire

// ===== src/aisfd_chk.sv =====
// ----------------------------------------------------------------------------
// aisfd_chk
// Port-level checks of the analog input scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aisfd_chk import aisfd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [2:0] m_tuser
);

	logic seen_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_out_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			seen_out_q <= 1'b1;
		end
	end

	// stalled result beat stays valid with its quality and report flag unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
		else $error("result beat dropped or changed while stalled");

	// one item in flight: ready drops right after an input beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// a result never carries the waiting-for-data quality
	a_qual_settled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == QUAL_GOOD) || (m_tuser[1:0] == QUAL_NOT_CONN))
		else $error("result quality still waiting for data");

	// first result after reset leaves the waiting quality, so it is reported
	a_first_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !seen_out_q |-> m_tuser[2])
		else $error("first result after reset not reported");

endmodule

bind analog_input_scaler_filter_deadband aisfd_chk u_aisfd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the analog input scaler, filter and deadband block.
// A directed stimulus table comes first: reset-state items with known
// readings, then clamp, deadband, report-period, filter, threshold, inverted
// and degenerate range cases. Random settings phases follow. Every reading is
// compared against a fixed or bit-accurate predicted value, with random gaps and
// stalls on both streams and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import aisfd_pkg::*;

	localparam int    STALL_LIMIT    = 5000;
	localparam int    HOLDOFF_CYCLES = 600;
	localparam int    PHASES         = 10;
	localparam int    PHASE_ITEMS    = 50;
	localparam mode_t MODE_UNUSED    = 2'd3;

	typedef struct packed {
		logic [15:0] raw;
		logic        link;
		logic [47:0] now;
		logic        sim;
		logic [31:0] simv;
	} sample_t;

	typedef struct packed {
		logic [31:0] value;
		qual_t       quality;
		logic        reported;
	} reading_t;

	typedef struct {
		bit       is_cfg;
		reg_idx_t addr;
		logic [31:0] data;
		sample_t  smp;
		bit       typed;
		reading_t want;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // raw_sample[15:0], now_us[63:16], sim_value[95:64]
	logic [1:0]  s_tuser;   // link_error, sim_enable
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // value
	logic [2:0]  m_tuser;   // quality[1:0], reported

	// predictor copy of the registers and of the block state
	logic [31:0] reg_copy [0:7] = '{default: '0};
	longint      held_value   = 0;
	logic [47:0] held_time    = '0;
	qual_t       held_quality = QUAL_WAITING;

	reading_t    expected_readings [$];
	reading_t    head;
	step_t       stim_table [$];
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	bit          calm         = 1'b0;
	bit          holdoff_req  = 1'b0;
	logic [47:0] clock_us     = '0;

	analog_input_scaler_filter_deadband dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic reading_t condition_sample(sample_t s);
		reading_t r;
		longint   raw, rlo, rhi, elo, ehi, thr, v, dt, t, dev, band;
		mode_t    mode;
		qual_t    prev_q;
		raw    = longint'($signed(s.raw));
		rlo    = longint'($signed(reg_copy[REG_RAW_LOW][15:0]));
		rhi    = longint'($signed(reg_copy[REG_RAW_HIGH][15:0]));
		elo    = longint'($signed(reg_copy[REG_ENG_LOW]));
		ehi    = longint'($signed(reg_copy[REG_ENG_HIGH]));
		thr    = longint'($signed(reg_copy[REG_THRESHOLD]));
		mode   = reg_copy[REG_MODE][1:0];
		prev_q = held_quality;
		dt = (s.now >= held_time) ? longint'(s.now - held_time) : longint'(held_time - s.now);
		if (s.sim) begin
			v = longint'($signed(s.simv));
			held_quality = QUAL_GOOD;
		end else begin
			held_quality = s.link ? QUAL_NOT_CONN : QUAL_GOOD;
			if (rhi != rlo && ehi != elo) begin
				t = longint'(reg_copy[REG_FILTER_MS][15:0]) * 1000;
				v = elo + ((ehi - elo) * (raw - rlo)) / (rhi - rlo);
				// ceiling first, so an inverted range always lands on eng_low
				if (v > ehi) v = ehi;
				if (v < elo) v = elo;
				if (dt != 0 && t != 0)
					v = v - ((v - held_value) * t) / (t + dt);
				if (mode == MODE_ABOVE)
					v = (v >= thr) ? Q_ONE : 0;
				else if (mode == MODE_BELOW)
					v = (v < thr) ? Q_ONE : 0;
			end else begin
				// degenerate range: raw word passes as an integer
				v = raw * Q_ONE;
			end
		end
		dev  = v - held_value;
		if (dev < 0) dev = -dev;
		band = longint'(reg_copy[REG_DEADBAND][30:0]);
		r.reported = (dev >= band) || (prev_q != held_quality) || (dt > REPORT_US);
		if (r.reported) begin
			held_value = v;
			held_time  = s.now;
		end
		r.value   = v[31:0];
		r.quality = held_quality;
		return r;
	endfunction

	function automatic step_t reg_step(reg_idx_t a, logic [31:0] d);
		step_t r;
		r.is_cfg = 1'b1;
		r.addr   = a;
		r.data   = d;
		r.smp    = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic step_t sample_step(logic [15:0] raw, bit link, logic [47:0] now,
			bit sim, logic [31:0] simv);
		step_t r;
		r.is_cfg = 1'b0;
		r.addr   = REG_RAW_LOW;
		r.data   = '0;
		r.smp    = '{raw, link, now, sim, simv};
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	// reset settings: degenerate ranges and zero deadband, so every step reports
	function automatic step_t known_step(logic [15:0] raw, bit link, logic [47:0] now,
			bit sim, logic [31:0] simv, logic [31:0] value, qual_t q);
		step_t r;
		r       = sample_step(raw, link, now, sim, simv);
		r.typed = 1'b1;
		r.want  = '{value, q, 1'b1};
		return r;
	endfunction

	// append one row to the stimulus table
	function automatic void add_step(step_t st);
		stim_table.insert(stim_table.size(), st);
	endfunction

	function automatic sample_t next_sample();
		sample_t s;
		int      lo, hi, span, x;
		lo = int'($signed(reg_copy[REG_RAW_LOW][15:0]));
		hi = int'($signed(reg_copy[REG_RAW_HIGH][15:0]));
		if (lo > hi) begin
			x  = lo;
			lo = hi;
			hi = x;
		end
		span = hi - lo;
		if ($urandom_range(99) < 70) begin
			// mostly around the raw range, a little past both ends
			x = lo - span / 8 + int'($urandom_range(span + span / 4));
			if (x < -32768) x = -32768;
			if (x > 32767) x = 32767;
			s.raw = x[15:0];
		end else begin
			s.raw = 16'($urandom);
		end
		x = $urandom_range(99);
		if (x < 5) begin
			// same instant again
		end else if (x < 10) begin
			clock_us = clock_us - 48'($urandom_range(1, 100_000));
		end else if (x < 15) begin
			clock_us = clock_us + 48'($urandom_range(60_000_001, 120_000_000));
		end else if (x < 18) begin
			clock_us = 48'({$urandom, $urandom});
		end else begin
			clock_us = clock_us + 48'($urandom_range(1, 200_000));
		end
		s.now  = clock_us;
		s.link = ($urandom_range(99) < 10);
		s.sim  = ($urandom_range(99) < 10);
		s.simv = $urandom;
		return s;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		reg_copy[idx] = data;
		@(posedge clk);
	endtask

	task automatic load_settings(int kind);
		logic [31:0] regs [0:7];
		int          rl, rh, x;
		longint      el, eh, span;
		case (kind)
			0: begin
				regs[REG_RAW_LOW]   = 32'h0000_8000;
				regs[REG_RAW_HIGH]  = 32'h0000_7FFF;
				regs[REG_ENG_LOW]   = 32'h8000_0000;
				regs[REG_ENG_HIGH]  = 32'h7FFF_FFFF;
				regs[REG_FILTER_MS] = 32'h0000_FFFF;
				regs[REG_MODE]      = 32'(MODE_ANALOG);
				regs[REG_THRESHOLD] = '0;
				regs[REG_DEADBAND]  = '0;
			end
			1: begin
				regs[REG_RAW_LOW]   = '0;
				regs[REG_RAW_HIGH]  = 32'd1;
				regs[REG_ENG_LOW]   = '0;
				regs[REG_ENG_HIGH]  = 32'(Q_ONE);
				regs[REG_FILTER_MS] = 32'd1;
				regs[REG_MODE]      = 32'(MODE_ABOVE);
				regs[REG_THRESHOLD] = 32'h8000_0000;
				regs[REG_DEADBAND]  = 32'h7FFF_FFFF;
			end
			2: begin
				// every bit random, unused high bits included
				for (int i = 0; i < 8; i++) regs[i] = $urandom;
			end
			default: begin
				rl = int'($urandom_range(8000)) - 4000;
				rh = rl + int'($urandom_range(1, 4000));
				x  = $urandom_range(99);
				if (x < 10) begin
					rh = rl;
				end else if (x < 25) begin
					x  = rl;
					rl = rh;
					rh = x;
				end else if (x < 35) begin
					rl = int'($urandom_range(65535)) - 32768;
					rh = int'($urandom_range(65535)) - 32768;
				end
				el = (longint'($urandom_range(2000)) - 1000) * Q_ONE
					+ longint'($urandom_range(65535));
				eh = el + longint'($urandom_range(1, 500)) * Q_ONE;
				x  = $urandom_range(99);
				if (x < 10) begin
					eh = el;
				end else if (x < 20) begin
					span = el;
					el   = eh;
					eh   = span;
				end
				span = (eh > el) ? eh - el : el - eh;
				regs[REG_RAW_LOW]  = 32'(rl);
				regs[REG_RAW_HIGH] = 32'(rh);
				regs[REG_ENG_LOW]  = el[31:0];
				regs[REG_ENG_HIGH] = eh[31:0];
				x = $urandom_range(99);
				regs[REG_FILTER_MS] = (x < 30) ? 32'd0 :
					(x < 90) ? $urandom_range(1, 2000) : $urandom_range(2001, 65535);
				regs[REG_MODE]      = 32'($urandom_range(3));
				regs[REG_THRESHOLD] = 32'(el + (eh - el) * longint'($urandom_range(100)) / 100);
				x = $urandom_range(99);
				regs[REG_DEADBAND]  = (x < 15) ? 32'd0 :
					(x < 85) ? $urandom_range(32'(span / 8)) : ($urandom & 32'h7FFF_FFFF);
			end
		endcase
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), regs[i]);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(sample_t s, bit fixed, reading_t fixed_want);
		reading_t want;
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(19) == 0)
				repeat ($urandom_range(10, 80)) @(posedge clk);
			else
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {s.simv, s.now, s.raw};
		s_tuser  <= {s.sim, s.link};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = condition_sample(s);
		expected_readings.insert(expected_readings.size(), fixed ? fixed_want : want);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	// output side: random stalls, occasional long ones, one long hold-off
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (calm || $urandom_range(99) >= 33) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				if ($urandom_range(19) == 0)
					repeat ($urandom_range(10, 150)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected beat: value %h quality %0d reported %b",
					$time, m_tdata, m_tuser[1:0], m_tuser[2]);
				mismatches++;
			end else begin
				head = expected_readings.pop_front();
				if (m_tdata !== head.value) begin
					$display("%0t: value expected %h got %h", $time, head.value, m_tdata);
					mismatches++;
				end
				if (m_tuser[1:0] !== head.quality) begin
					$display("%0t: quality expected %0d got %0d", $time, head.quality,
						m_tuser[1:0]);
					mismatches++;
				end
				if (m_tuser[2] !== head.reported) begin
					$display("%0t: reported expected %b got %b", $time, head.reported,
						m_tuser[2]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("analog_input_scaler_filter_deadband verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit in_flight;
		in_flight = 1'b0;
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_addr <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;

		// reset settings: extremes of every field with readings known up front
		add_step(known_step(16'h7FFF, 0, 48'd10, 0, '0, 32'h7FFF_0000, QUAL_GOOD));
		add_step(known_step(16'h8000, 0, 48'd20, 0, '0, 32'h8000_0000, QUAL_GOOD));
		add_step(known_step(16'h0001, 1, 48'd30, 0, '0, 32'h0001_0000,
			QUAL_NOT_CONN));
		add_step(known_step(16'h0000, 0, 48'd40, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			QUAL_GOOD));
		// simulation overrides a link error
		add_step(known_step(16'hFFFF, 1, 48'd50, 1, 32'h8000_0000, 32'h8000_0000,
			QUAL_GOOD));
		add_step(known_step(16'hFFFF, 0, 48'hFFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF,
			32'hFFFF_0000, QUAL_GOOD));
		// time jumps backward
		add_step(known_step(16'h0000, 0, 48'd0, 0, '0, 32'h0000_0000, QUAL_GOOD));

		// -1000..1000 raw onto -50.0..50.0, deadband 1.0
		add_step(reg_step(REG_RAW_LOW, 32'h0000_FC18));
		add_step(reg_step(REG_RAW_HIGH, 32'h0000_03E8));
		add_step(reg_step(REG_ENG_LOW, 32'hFFCE_0000));
		add_step(reg_step(REG_ENG_HIGH, 32'h0032_0000));
		add_step(reg_step(REG_DEADBAND, 32'h0001_0000));
		add_step(sample_step(16'h0000, 0, 48'd100, 0, '0));
		add_step(sample_step(16'h07D0, 0, 48'd200, 0, '0));
		add_step(sample_step(16'hF830, 0, 48'd300, 0, '0));
		add_step(sample_step(16'h01F4, 0, 48'd300, 0, '0));
		// change below the deadband, then exactly 60 s, then just past it
		add_step(sample_step(16'h01F5, 0, 48'd400, 0, '0));
		add_step(sample_step(16'h01F5, 0, 48'd60_000_300, 0, '0));
		add_step(sample_step(16'h01F5, 0, 48'd60_000_301, 0, '0));

		add_step(reg_step(REG_FILTER_MS, 32'd100));
		add_step(sample_step(16'h03E8, 0, 48'd60_050_301, 0, '0));
		add_step(sample_step(16'h03E8, 0, 48'd60_100_301, 0, '0));

		add_step(reg_step(REG_THRESHOLD, 32'h000A_0000));
		add_step(reg_step(REG_MODE, 32'(MODE_ABOVE)));
		add_step(sample_step(16'h012C, 0, 48'd60_150_301, 0, '0));
		add_step(sample_step(16'hFED4, 0, 48'd60_200_301, 0, '0));
		add_step(reg_step(REG_MODE, 32'(MODE_BELOW)));
		add_step(sample_step(16'hFED4, 0, 48'd60_250_301, 0, '0));
		// unused mode behaves as analog
		add_step(reg_step(REG_MODE, 32'(MODE_UNUSED)));
		add_step(sample_step(16'h0064, 0, 48'd60_300_301, 0, '0));

		// inverted engineering range clamps to eng_low
		add_step(reg_step(REG_ENG_LOW, 32'h0032_0000));
		add_step(reg_step(REG_ENG_HIGH, 32'hFFCE_0000));
		add_step(reg_step(REG_MODE, 32'(MODE_ANALOG)));
		add_step(reg_step(REG_FILTER_MS, 32'd0));
		add_step(sample_step(16'h0000, 0, 48'd60_350_301, 0, '0));
		// equal raw limits pass the raw word through
		add_step(reg_step(REG_RAW_HIGH, 32'h0000_FC18));
		add_step(sample_step(16'h04D2, 0, 48'd60_400_301, 0, '0));
		// widest deadband: only a quality change reports
		add_step(reg_step(REG_DEADBAND, 32'h7FFF_FFFF));
		add_step(sample_step(16'h000A, 0, 48'd60_450_301, 0, '0));
		add_step(sample_step(16'h000A, 1, 48'd60_500_301, 0, '0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				if (in_flight) begin
					drain();
					in_flight = 1'b0;
				end
				write_reg(stim_table[i].addr, stim_table[i].data);
			end else begin
				if (cfg_we) cfg_we <= 1'b0;
				send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
				in_flight = 1'b1;
			end
		end
		clock_us = 48'd60_500_301;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			load_settings((ph == 0) ? 0 : (ph == 1) ? 2 : (ph == 6) ? 1 : 3);
			calm = (ph == 4);
			// output held off while the input keeps offering beats
			if (ph == 3) holdoff_req = 1'b1;
			repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, '0);
		end
		calm = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("analog_input_scaler_filter_deadband verification clean");
		else
			$display("analog_input_scaler_filter_deadband verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aisfd_pkg.sv
src/aisfd_div.sv
src/aisfd_dp.sv
src/aisfd_ctrl.sv
src/analog_input_scaler_filter_deadband.sv
src/aisfd_chk.sv
tb/sv/tb_top.sv
